// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared constants, status codes and cell command type.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W          = 32;
    localparam int PRIO_FIELD_W    = 8;
    localparam int FILL_W          = 5;
    localparam int STATUS_W        = 2;
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_PRIO_BITS   = 8;

    localparam int S_TDATA_W = ((DATA_W + PRIO_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + DATA_W + PRIO_FIELD_W + FILL_W + 7) / 8) * 8;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_cmd_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain; shifts right on insert, left on removal.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_W = spq_pkg::DEF_PRIO_BITS
) (
    input  logic                       clk,
    input  spq_pkg::cell_cmd_t         cmd,
    input  logic                       occupied,
    input  logic [PRIO_W-1:0]          new_prio,
    input  logic [spq_pkg::DATA_W-1:0] new_data,
    input  logic                       left_greater,
    input  logic [PRIO_W-1:0]          left_prio,
    input  logic [spq_pkg::DATA_W-1:0] left_data,
    input  logic [PRIO_W-1:0]          right_prio,
    input  logic [spq_pkg::DATA_W-1:0] right_data,
    output logic                       greater,
    output logic [PRIO_W-1:0]          prio,
    output logic [spq_pkg::DATA_W-1:0] data
);
    import spq_pkg::*;

    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // An empty slot or one holding a larger number is where the new item goes or shifts past.
    assign greater = !occupied || (prio_reg > new_prio);

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (cmd.enq && greater)
        begin
            if (left_greater)
            begin
                prio_next = left_prio;
                data_next = left_data;
            end
            else
            begin
                prio_next = new_prio;
                data_next = new_data;
            end
        end
        else if (cmd.deq)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

// File: rtl/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue
// Sorted min-first queue built as a chain of cells with a registered result.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle unless the output stalls, and returns
// one result item for each in the cycle after acceptance, through a single
// output register; every cell compares its own priority with the incoming one
// in parallel, so an insert or a removal completes in the cycle it is accepted.
// Lower priority numbers leave first and equal priorities leave in arrival order.
module stable_priority_queue_top #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIO_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from low: in_data[31:0], in_priority[39:32].
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from low: op[0].
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from low: status[1:0], out_data[33:2], out_priority[41:34],
    // fill_count[46:42].
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                     accept;
    logic                     is_deq;
    logic [DATA_W-1:0]        in_data;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic                     is_empty;
    logic                     is_full;
    cell_cmd_t                cmd;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic [M_TDATA_W-1:0]     result_reg;
    logic [M_TDATA_W-1:0]     result_next;

    logic [CAPACITY-1:0]      greater;
    logic [CAPACITY-1:0]      occupied;
    logic [PRIORITY_BITS-1:0] prio_q [CAPACITY];
    logic [DATA_W-1:0]        data_q [CAPACITY];

    status_t                  status;
    logic [DATA_W-1:0]        out_data;
    logic [PRIO_FIELD_W-1:0]  out_prio;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (op_t'(s_tuser[0]) == OP_DEQUEUE);
    assign in_data  = s_tdata[DATA_W-1:0];
    assign in_prio  = PRIORITY_BITS'(s_tdata[DATA_W +: PRIO_FIELD_W]);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign cmd.enq  = accept && !is_deq && !is_full;
    assign cmd.deq  = accept && is_deq && !is_empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                     lg;
            logic [PRIORITY_BITS-1:0] lp;
            logic [DATA_W-1:0]        ld;
            logic [PRIORITY_BITS-1:0] rp;
            logic [DATA_W-1:0]        rd;

            assign occupied[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign lg = 1'b0;
                assign lp = in_prio;
                assign ld = in_data;
            end
            else
            begin : g_body
                assign lg = greater[gi-1];
                assign lp = prio_q[gi-1];
                assign ld = data_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rp = prio_q[gi];
                assign rd = data_q[gi];
            end
            else
            begin : g_inner
                assign rp = prio_q[gi+1];
                assign rd = data_q[gi+1];
            end

            spq_cell #(
                .PRIO_W (PRIORITY_BITS)
            ) u_cell (
                .clk          (clk),
                .cmd          (cmd),
                .occupied     (occupied[gi]),
                .new_prio     (in_prio),
                .new_data     (in_data),
                .left_greater (lg),
                .left_prio    (lp),
                .left_data    (ld),
                .right_prio   (rp),
                .right_data   (rd),
                .greater      (greater[gi]),
                .prio         (prio_q[gi]),
                .data         (data_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        status   = ST_DONE;
        out_data = '0;
        out_prio = '0;
        if (is_deq)
        begin
            if (is_empty)
            begin
                status = ST_EMPTY;
            end
            else
            begin
                out_data = data_q[0];
                out_prio = PRIO_FIELD_W'(prio_q[0]);
            end
        end
        else if (is_full)
        begin
            status = ST_FULL;
        end

        result_next = M_TDATA_W'({FILL_W'(count_next), out_prio, out_data, status});

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg;

endmodule

// File: sim/stable_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Sends enqueue and dequeue items through the input stream and predicts each
// result with a sorted copy of the queue contents. Every returned item is
// compared field by field with the oldest prediction. The run starts with a
// directed part: a dequeue from empty, data and priority extremes, ties,
// filling to capacity, an enqueue when full, and a partial drain. Random phases
// follow that vary the enqueue rate, the spread of priorities and the idle
// time on both sides. In one phase the output is held off long enough for
// the input to stall.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int DEPTH          = DEF_CAPACITY;
    localparam int PRIO_W         = DEF_PRIO_BITS;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 58;
    localparam int PRESSURE_PHASE = 6;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 100;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int TIMEOUT_CYCLES = 100_000;

    localparam logic [DATA_W-1:0] FILL_DATA [DEPTH] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0002,
        32'h0000_0003, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 32'hFFFF_0000
    };
    localparam logic [PRIO_FIELD_W-1:0] FILL_PRIO [DEPTH] = '{
        8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd1, 8'd5, 8'd5,
        8'd5, 8'd200, 8'd254, 8'd1, 8'd0, 8'd128, 8'd3, 8'd77
    };

    typedef struct packed {
        status_t                 status;
        logic [DATA_W-1:0]       data;
        logic [PRIO_FIELD_W-1:0] prio;
        logic [FILL_W-1:0]       fill;
    } response_t;

    class spq_scoreboard;
        logic [DATA_W-1:0] slot_data [DEPTH];
        logic [PRIO_W-1:0] slot_prio [DEPTH];
        int unsigned       stored;
        response_t         pending_responses [$];
        int unsigned       errors;

        function new();
            stored = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void note_request(op_t op, logic [DATA_W-1:0] d,
                                   logic [PRIO_FIELD_W-1:0] p);
            response_t         rsp;
            logic [PRIO_W-1:0] key;
            int unsigned       pos;
            int unsigned       i;
            rsp.status = ST_DONE;
            rsp.data   = '0;
            rsp.prio   = '0;
            key        = p[PRIO_W-1:0];
            pos        = 0;
            if (op == OP_DEQUEUE)
            begin
                if (stored == 0)
                begin
                    rsp.status = ST_EMPTY;
                end
                else
                begin
                    rsp.data = slot_data[0];
                    rsp.prio = PRIO_FIELD_W'(slot_prio[0]);
                    for (i = 1; i < stored; i++)
                    begin
                        slot_data[i-1] = slot_data[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    stored--;
                end
            end
            else if (stored >= DEPTH)
            begin
                rsp.status = ST_FULL;
            end
            else
            begin
                while (pos < stored && slot_prio[pos] <= key)
                    pos++;
                for (i = stored; i > pos; i--)
                begin
                    slot_data[i] = slot_data[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_data[pos] = d;
                slot_prio[pos] = key;
                stored++;
            end
            rsp.fill = FILL_W'(stored);
            pending_responses.push_back(rsp);
        endfunction

        task check_response(logic [M_TDATA_W-1:0] word);
            response_t got;
            response_t want;
            got.status = status_t'(word[STATUS_W-1:0]);
            got.data   = word[STATUS_W +: DATA_W];
            got.prio   = word[STATUS_W + DATA_W +: PRIO_FIELD_W];
            got.fill   = word[STATUS_W + DATA_W + PRIO_FIELD_W +: FILL_W];
            if (pending_responses.size() == 0)
            begin
                report($sformatf("unexpected result %h", word));
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d expected %0d", got.status, want.status));
            if (got.data !== want.data)
                report($sformatf("out_data got %h expected %h", got.data, want.data));
            if (got.prio !== want.prio)
                report($sformatf("out_priority got %0d expected %0d", got.prio, want.prio));
            if (got.fill !== want.fill)
                report($sformatf("fill_count got %0d expected %0d", got.fill, want.fill));
        endtask
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int unsigned            tx_max_gap   = 2;
    int unsigned            rx_max_stall = 2;
    int unsigned            rx_hold      = 0;

    spq_scoreboard          sb = new();

    stable_priority_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_response(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(op_t'(s_tuser[0]), s_tdata[DATA_W-1:0],
                                s_tdata[DATA_W +: PRIO_FIELD_W]);
        end
    end

    task automatic send_item(op_t op, logic [DATA_W-1:0] d, logic [PRIO_FIELD_W-1:0] p);
        int unsigned gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({p, d});
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random(int unsigned enq_pct, int unsigned prio_max);
        op_t op;
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        send_item(op, $urandom(), PRIO_FIELD_W'($urandom_range(0, prio_max)));
    endtask

    // The receiver picks up a requested hold-off at the start of its next item.
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned k;
        int unsigned enq_pct;
        int unsigned prio_max;
        int unsigned waited;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_DEQUEUE, '1, '1);
        for (k = 0; k < DEPTH; k++)
            send_item(OP_ENQUEUE, FILL_DATA[k], FILL_PRIO[k]);
        send_item(OP_ENQUEUE, 32'hCAFE_F00D, '0);
        for (k = 0; k < 6; k++)
            send_item(OP_DEQUEUE, $urandom(), PRIO_FIELD_W'($urandom_range(0, 255)));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0: enq_pct = 80;
                1: enq_pct = 20;
                2: enq_pct = 50;
                default: enq_pct = 65;
            endcase
            prio_max     = (phase % 3 == 1) ? 3 : 255;
            tx_max_gap   = (phase % 5 == 2) ? 0 : 6;
            rx_max_stall = (phase % 5 == 3) ? 0 : 6;
            if (phase == PRESSURE_PHASE)
            begin
                tx_max_gap = 0;
                rx_hold    = HOLD_CYCLES;
                for (k = 0; k < PRESSURE_ITEMS; k++)
                    send_random(50, prio_max);
            end
            for (k = 0; k < PHASE_ITEMS; k++)
                send_random(enq_pct, prio_max);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        waited = 0;
        while (sb.pending_responses.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_responses.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_responses.size()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_top.sv
sim/stable_priority_queue_top_tb.sv
